### rtl/sll_pkg.sv
package sll_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_FEATURE_COUNT = 3'd0;
	localparam cfg_index_t CFG_ACTION_COUNT  = 3'd1;
	localparam cfg_index_t CFG_DISCOUNT      = 3'd2;
	localparam cfg_index_t CFG_STEP_SIZE     = 3'd3;
	localparam cfg_index_t CFG_EXPLORE_RATE  = 3'd4;
	localparam cfg_index_t CFG_TRACE_DECAY   = 3'd5;

	// trace value for 1.0 in Q1.16
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// status of the serial modulo unit
	typedef struct packed {
		logic busy;
		logic done;
	} mod_status_t;

endpackage

### rtl/sarsa_lambda_linear_learner_top.sv
// Feature bits that do not close a state are taken while idle; one item is in work at a time.
// A closing bit runs the action sums over the loaded features, the pick scan, the weight
// update over every entry and the trace set for the loaded bits; a stalled result holds
// it in its last state. A reset item clears every entry of the trace memory.
// After reset the weight and trace memories are cleared, one entry per cycle,
// before the first item is accepted.
module sarsa_lambda_linear_learner_top #(
	parameter int MAX_FEATURES = 512,
	parameter int MAX_ACTIONS  = 32,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic                      feature_bit,
	input  logic                      last_feature,
	input  logic signed [15:0]        reward,
	input  logic [15:0]               explore_draw,
	input  logic [15:0]               pick_draw,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [4:0]                chosen_action,
	output logic                      explored,
	output logic signed [31:0]        chosen_value,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  sll_pkg::cfg_index_t       cfg_index,
	input  logic [15:0]               cfg_data
);
	import sll_pkg::*;

	localparam int FIW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int FCW   = $clog2(MAX_FEATURES + 1);
	localparam int AIW   = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
	localparam int ACW   = $clog2(MAX_ACTIONS + 1);
	localparam int DEPTH = MAX_FEATURES * MAX_ACTIONS;
	localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SCW   = $clog2(DEPTH + 1);
	localparam int ACCW  = WEIGHT_BITS + FCW;

	localparam logic signed [63:0] WMAX = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;
	localparam logic signed [63:0] QMAX = 64'sd2147483647;
	localparam logic signed [63:0] QMIN = -64'sd2147483648;

	// states
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_CLR   = 5'd1;
	localparam logic [4:0] ST_CLRT  = 5'd2;
	localparam logic [4:0] ST_SUM   = 5'd3;
	localparam logic [4:0] ST_SDRN  = 5'd4;
	localparam logic [4:0] ST_MODS  = 5'd5;
	localparam logic [4:0] ST_MODW  = 5'd6;
	localparam logic [4:0] ST_SCAN  = 5'd7;
	localparam logic [4:0] ST_QV    = 5'd8;
	localparam logic [4:0] ST_DELTA = 5'd9;
	localparam logic [4:0] ST_STEPM = 5'd10;
	localparam logic [4:0] ST_STEPR = 5'd11;
	localparam logic [4:0] ST_UPD   = 5'd12;
	localparam logic [4:0] ST_UDRN  = 5'd13;
	localparam logic [4:0] ST_SETT  = 5'd14;
	localparam logic [4:0] ST_TDRN  = 5'd15;
	localparam logic [4:0] ST_DONE  = 5'd16;

	// configuration registers
	logic [9:0]  feature_count_q;
	logic [5:0]  action_count_q;
	logic [15:0] discount_q;
	logic [15:0] step_size_q;
	logic [15:0] explore_rate_q;
	logic [15:0] trace_decay_q;

	// control and datapath registers
	logic [4:0]              state_q;
	logic [SCW-1:0]          clr_q;
	logic [FCW-1:0]          lp_q;
	logic [FCW-1:0]          used_q;
	logic [FCW-1:0]          i_q;
	logic [ACW-1:0]          a_q;
	logic [SCW-1:0]          base_q;
	logic [SCW-1:0]          total_q;
	logic [SCW-1:0]          idx_q;
	logic [SCW-1:0]          cbase_q;
	logic signed [ACCW-1:0]  acc_q;
	logic signed [31:0]      best_q;
	logic [ACW-1:0]          ties_q;
	logic signed [31:0]      av_q [MAX_ACTIONS];
	logic [ACW-1:0]          k_q;
	logic [ACW-1:0]          cnt_q;
	logic [AIW-1:0]          choice_q;
	logic signed [31:0]      q_q;
	logic signed [31:0]      prev_q;
	logic signed [15:0]      reward_q;
	logic                    explore_q;
	logic [15:0]             pick_q;
	logic signed [48:0]      gq_q;
	logic [31:0]             glp_q;
	logic signed [33:0]      delta_q;
	logic signed [50:0]      stp_q;
	logic signed [33:0]      step_q;
	logic [16:0]             gl_q;
	logic                    out_valid_q;
	logic [4:0]              out_action_q;
	logic                    out_explored_q;
	logic signed [31:0]      out_value_q;

	// pipeline registers
	logic                    s_v_s1;
	logic                    s_en_s1;
	logic                    s_last_s1;
	logic [AIW-1:0]          s_a_s1;
	logic                    u_v_s1;
	logic [SW-1:0]           u_addr_s1;
	logic                    u_v_s2;
	logic [SW-1:0]           u_addr_s2;
	logic signed [WEIGHT_BITS-1:0] u_w_s2;
	logic                    u_nz_s2;
	logic signed [51:0]      u_prod_s2;
	logic [33:0]             u_tp_s2;
	logic                    t_v_s1;
	logic [SW-1:0]           t_addr_s1;

	// memories and registered read data
	logic signed [WEIGHT_BITS-1:0] w_mem [DEPTH];
	logic [16:0]                   t_mem [DEPTH];
	logic                          f_mem [MAX_FEATURES];
	logic signed [WEIGHT_BITS-1:0] w_rd;
	logic [16:0]                   t_rd;
	logic                          f_rd;

	// combinational
	logic [FCW-1:0]          nf_eff;
	logic [ACW-1:0]          na_eff;
	logic [FCW-1:0]          umax;
	logic                    i_last;
	logic                    a_last;
	logic                    in_acc;
	logic                    load_we;
	logic [FCW-1:0]          lp_next;
	logic [SW-1:0]           w_raddr;
	logic                    w_we;
	logic [SW-1:0]           w_waddr;
	logic signed [WEIGHT_BITS-1:0] w_wdata;
	logic                    t_we;
	logic [SW-1:0]           t_waddr;
	logic [16:0]             t_wdata;
	logic signed [ACCW-1:0]  acc_sum;
	logic signed [63:0]      acc_ext;
	logic signed [31:0]      sum_val;
	logic signed [32:0]      rnd_gq;
	logic signed [35:0]      inc;
	logic signed [63:0]      wsum;
	logic signed [WEIGHT_BITS-1:0] nw;
	logic [16:0]             nt;
	logic                    scan_hit;
	logic                    mod_start;
	logic [ACW-1:0]          mod_div;
	mod_status_t             mod_st;
	logic [ACW-1:0]          mod_rem;

	// effective counts
	assign nf_eff = FCW'((feature_count_q == 10'd0) ? 1 :
		((int'(feature_count_q) > MAX_FEATURES) ? MAX_FEATURES : int'(feature_count_q)));
	assign na_eff = ACW'((action_count_q == 6'd0) ? 1 :
		((int'(action_count_q) > MAX_ACTIONS) ? MAX_ACTIONS : int'(action_count_q)));

	assign umax   = (used_q == '0) ? FCW'(1) : used_q;
	assign i_last = (i_q == umax - FCW'(1));
	assign a_last = (a_q == na_eff - ACW'(1));

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign load_we   = in_acc && !action && (lp_q < nf_eff);
	assign lp_next   = (lp_q < nf_eff) ? lp_q + FCW'(1) : lp_q;
	assign cfg_ready = 1'b1;

	// sum accumulation at stage 1
	assign acc_sum = acc_q + ((s_en_s1 && f_rd) ? ACCW'(w_rd) : ACCW'(0));
	assign acc_ext = 64'(acc_sum);
	assign sum_val = (acc_ext > QMAX) ? 32'sh7fffffff :
		((acc_ext < QMIN) ? 32'sh80000000 : 32'(acc_ext));

	// update arithmetic at stage 2
	assign rnd_gq = 33'((gq_q + 49'sd32768) >>> 16);
	assign inc    = 36'((u_prod_s2 + 52'sd32768) >>> 16);
	assign wsum   = 64'(u_w_s2) + 64'(inc);
	assign nw     = (wsum > WMAX) ? WEIGHT_BITS'(WMAX) :
		((wsum < WMIN) ? WEIGHT_BITS'(WMIN) : WEIGHT_BITS'(wsum));
	assign nt     = 17'((u_tp_s2 + 34'd32768) >> 16);

	assign scan_hit = explore_q || (av_q[k_q[AIW-1:0]] == best_q);

	// memory port selection
	assign w_raddr = (state_q == ST_UPD) ? idx_q[SW-1:0] : SW'(base_q + SCW'(i_q));

	always_comb begin
		w_we    = 1'b0;
		w_waddr = u_addr_s2;
		w_wdata = nw;
		if (state_q == ST_CLR) begin
			w_we    = 1'b1;
			w_waddr = clr_q[SW-1:0];
			w_wdata = '0;
		end else if (u_v_s2 && u_nz_s2) begin
			w_we = 1'b1;
		end
	end

	always_comb begin
		t_we    = 1'b0;
		t_waddr = u_addr_s2;
		t_wdata = nt;
		if (state_q == ST_CLR || state_q == ST_CLRT) begin
			t_we    = 1'b1;
			t_waddr = clr_q[SW-1:0];
			t_wdata = '0;
		end else if (u_v_s2 && u_nz_s2) begin
			t_we = 1'b1;
		end else if (t_v_s1 && f_rd) begin
			t_we    = 1'b1;
			t_waddr = t_addr_s1;
			t_wdata = ONE_Q16;
		end
	end

	// weight memory
	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_waddr] <= w_wdata;
		end
		w_rd <= w_mem[w_raddr];
	end

	// trace memory
	always_ff @(posedge clk) begin
		if (t_we) begin
			t_mem[t_waddr] <= t_wdata;
		end
		t_rd <= t_mem[idx_q[SW-1:0]];
	end

	// active feature flags
	always_ff @(posedge clk) begin
		if (load_we) begin
			f_mem[lp_q[FIW-1:0]] <= feature_bit;
		end
		f_rd <= f_mem[i_q[FIW-1:0]];
	end

	// modulo unit for the random picks
	assign mod_start = (state_q == ST_MODS);
	assign mod_div   = explore_q ? na_eff : ties_q;

	sll_mod #(.DW(ACW)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (pick_q),
		.divisor   (mod_div),
		.status    (mod_st),
		.remainder (mod_rem)
	);

	// pipeline stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_v_s1 <= 1'b0;
			u_v_s1 <= 1'b0;
			u_v_s2 <= 1'b0;
			t_v_s1 <= 1'b0;
		end else begin
			s_v_s1 <= (state_q == ST_SUM);
			u_v_s1 <= (state_q == ST_UPD);
			u_v_s2 <= u_v_s1;
			t_v_s1 <= (state_q == ST_SETT);
		end
	end

	always_ff @(posedge clk) begin
		s_en_s1   <= (i_q < used_q);
		s_last_s1 <= i_last;
		s_a_s1    <= a_q[AIW-1:0];
		u_addr_s1 <= idx_q[SW-1:0];
		u_addr_s2 <= u_addr_s1;
		u_w_s2    <= w_rd;
		u_nz_s2   <= (t_rd != 17'd0);
		u_prod_s2 <= step_q * $signed({1'b0, t_rd});
		u_tp_s2   <= t_rd * gl_q;
		t_addr_s1 <= SW'(cbase_q + SCW'(i_q));
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_count_q <= 10'd160;
			action_count_q  <= 6'd18;
			discount_q      <= 16'd64881;
			step_size_q     <= 16'd6554;
			explore_rate_q  <= 16'd3277;
			trace_decay_q   <= 16'd58982;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FEATURE_COUNT: feature_count_q <= cfg_data[9:0];
				CFG_ACTION_COUNT:  action_count_q  <= cfg_data[5:0];
				CFG_DISCOUNT:      discount_q      <= cfg_data;
				CFG_STEP_SIZE:     step_size_q     <= cfg_data;
				CFG_EXPLORE_RATE:  explore_rate_q  <= cfg_data;
				CFG_TRACE_DECAY:   trace_decay_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// action value table, filled as each action's sum closes
	always_ff @(posedge clk) begin
		if (s_v_s1 && s_last_s1) begin
			av_q[s_a_s1] <= sum_val;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			lp_q        <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
			used_q      <= '0;
			i_q         <= '0;
			a_q         <= '0;
			base_q      <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			acc_q       <= '0;
			ties_q      <= '0;
		end else begin
			// the done state reloads the result register itself
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			// sum stage 1
			if (s_v_s1) begin
				if (s_last_s1) begin
					acc_q <= '0;
					if (s_a_s1 == '0 || sum_val > best_q) begin
						best_q <= sum_val;
						ties_q <= ACW'(1);
					end else if (sum_val == best_q) begin
						ties_q <= ties_q + ACW'(1);
					end
				end else begin
					acc_q <= acc_sum;
				end
			end

			unique case (state_q)
				ST_CLR, ST_CLRT: begin
					if (clr_q == SCW'(DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + SCW'(1);
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (action) begin
							prev_q  <= '0;
							lp_q    <= '0;
							clr_q   <= '0;
							state_q <= ST_CLRT;
						end else begin
							lp_q <= lp_next;
							if (last_feature) begin
								used_q    <= (lp_next < nf_eff) ? lp_next : nf_eff;
								reward_q  <= reward;
								explore_q <= (explore_draw < explore_rate_q);
								pick_q    <= pick_draw;
								i_q       <= '0;
								a_q       <= '0;
								base_q    <= '0;
								acc_q     <= '0;
								total_q   <= SCW'(SCW'(nf_eff) * SCW'(na_eff));
								state_q   <= ST_SUM;
							end
						end
					end
				end
				ST_SUM: begin
					if (i_last) begin
						i_q    <= '0;
						a_q    <= a_q + ACW'(1);
						base_q <= base_q + SCW'(nf_eff);
						if (a_last) begin
							state_q <= ST_SDRN;
						end
					end else begin
						i_q <= i_q + FCW'(1);
					end
				end
				ST_SDRN: begin
					state_q <= ST_MODS;
				end
				ST_MODS: begin
					state_q <= ST_MODW;
				end
				ST_MODW: begin
					if (mod_st.done) begin
						cnt_q   <= mod_rem;
						k_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					k_q <= k_q + ACW'(1);
					if (scan_hit) begin
						if (cnt_q == '0) begin
							choice_q <= k_q[AIW-1:0];
							q_q      <= av_q[k_q[AIW-1:0]];
							state_q  <= ST_QV;
						end else begin
							cnt_q <= cnt_q - ACW'(1);
						end
					end
				end
				ST_QV: begin
					gq_q    <= q_q * $signed({1'b0, discount_q});
					glp_q   <= discount_q * trace_decay_q;
					cbase_q <= SCW'(SCW'(choice_q) * SCW'(nf_eff));
					state_q <= ST_DELTA;
				end
				ST_DELTA: begin
					delta_q <= 34'((64'(reward_q) <<< 16) + 64'(rnd_gq) - 64'(prev_q));
					state_q <= ST_STEPM;
				end
				ST_STEPM: begin
					stp_q   <= delta_q * $signed({1'b0, step_size_q});
					state_q <= ST_STEPR;
				end
				ST_STEPR: begin
					step_q  <= 34'((stp_q + 51'sd32768) >>> 16);
					gl_q    <= 17'((glp_q + 32'd32768) >> 16);
					idx_q   <= '0;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					idx_q <= idx_q + SCW'(1);
					if (idx_q == total_q - SCW'(1)) begin
						state_q <= ST_UDRN;
					end
				end
				ST_UDRN: begin
					if (!u_v_s1 && !u_v_s2) begin
						i_q     <= '0;
						state_q <= (used_q == '0) ? ST_DONE : ST_SETT;
					end
				end
				ST_SETT: begin
					i_q <= i_q + FCW'(1);
					if (i_q == used_q - FCW'(1)) begin
						state_q <= ST_TDRN;
					end
				end
				ST_TDRN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						out_action_q   <= 5'(choice_q);
						out_explored_q <= explore_q;
						out_value_q    <= q_q;
						prev_q         <= q_q;
						lp_q           <= '0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign chosen_action = out_action_q;
	assign explored      = out_explored_q;
	assign chosen_value  = out_value_q;

	// a result appears only out of the final state of a closing bit
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done state");

	// decayed traces never exceed one
	a_trace_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(u_v_s2 && u_nz_s2) |-> nt <= ONE_Q16)
		else $error("decayed trace above one");

	// the pick scan finds its action within the action count
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> k_q < na_eff)
		else $error("pick scan ran past the last action");

	// waiting on the modulo unit only while it runs or finishes
	a_mod_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MODW |-> mod_st.busy || mod_st.done)
		else $error("waiting on an idle modulo unit");

endmodule

### rtl/sll_mod.sv
module sll_mod #(
	parameter int DW = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [15:0]           dividend,
	input  logic [DW-1:0]         divisor,
	output sll_pkg::mod_status_t  status,
	output logic [DW-1:0]         remainder
);
	import sll_pkg::*;

	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [15:0]   num_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, num_q[15]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			num_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= dividend;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[14:0], 1'b0};
				rem_q <= (trial >= {1'b0, divisor}) ? diff[DW-1:0] : trial[DW-1:0];
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule
